// File: design/svfe_pkg.sv
// Shared types, constants, microcode program and arithmetic helpers of the echo audio chain.
package svfe_pkg;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] t_step;

    // multiplier A operand select
    localparam logic [2:0] MA_BAND  = 3'd0;
    localparam logic [2:0] MA_HIGH  = 3'd1;
    localparam logic [2:0] MA_ENTRY = 3'd2;
    localparam logic [2:0] MA_DRY   = 3'd3;
    localparam logic [2:0] MA_CLIP  = 3'd4;
    localparam logic [2:0] MA_MIX   = 3'd5;

    // multiplier B operand select
    localparam logic [2:0] MB_F   = 3'd0;
    localparam logic [2:0] MB_Q   = 3'd1;
    localparam logic [2:0] MB_TAP = 3'd2;
    localparam logic [2:0] MB_DRY = 3'd3;
    localparam logic [2:0] MB_PCM = 3'd4;

    localparam logic [15:0] TAP_GAIN    = 16'd280;
    localparam logic [15:0] DRY_FB_GAIN = 16'd45875;
    localparam logic [15:0] PCM_SCALE   = 16'd30000;

    // datapath actions
    localparam logic [3:0] ACT_NONE  = 4'd0;
    localparam logic [3:0] ACT_LATCH = 4'd1;
    localparam logic [3:0] ACT_LOW   = 4'd2;
    localparam logic [3:0] ACT_HIGH  = 4'd3;
    localparam logic [3:0] ACT_BAND  = 4'd4;
    localparam logic [3:0] ACT_DLY   = 4'd5;
    localparam logic [3:0] ACT_FB    = 4'd6;
    localparam logic [3:0] ACT_STORE = 4'd7;
    localparam logic [3:0] ACT_EMIT  = 4'd8;

    // sequencer jumps
    localparam logic [1:0] JMP_NEXT     = 2'd0;
    localparam logic [1:0] JMP_WAIT_IN  = 2'd1;
    localparam logic [1:0] JMP_WAIT_OUT = 2'd2;

    typedef struct packed {
        logic       mul_en;
        logic [2:0] a_sel;
        logic [2:0] b_sel;
        logic [3:0] act;
        logic [1:0] jmp;
    } t_ctrl;

    typedef struct packed {
        logic go;
        logic hold;
    } t_seq_cond;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl c;
        c = '{mul_en: 1'b0, a_sel: MA_BAND, b_sel: MB_F, act: ACT_NONE, jmp: JMP_NEXT};
        case (step)
            4'd0:  begin c.act = ACT_LATCH; c.jmp = JMP_WAIT_IN; end
            4'd1:  begin c.mul_en = 1'b1; c.a_sel = MA_BAND; c.b_sel = MB_F; end
            4'd2:  begin
                c.mul_en = 1'b1; c.a_sel = MA_BAND; c.b_sel = MB_Q; c.act = ACT_LOW;
            end
            4'd3:  begin c.act = ACT_HIGH; end
            4'd4:  begin c.mul_en = 1'b1; c.a_sel = MA_HIGH; c.b_sel = MB_F; end
            4'd5:  begin
                c.mul_en = 1'b1; c.a_sel = MA_ENTRY; c.b_sel = MB_TAP; c.act = ACT_BAND;
            end
            4'd6:  begin
                c.mul_en = 1'b1; c.a_sel = MA_DRY; c.b_sel = MB_DRY; c.act = ACT_DLY;
            end
            4'd7:  begin c.act = ACT_FB; end
            4'd8:  begin c.mul_en = 1'b1; c.a_sel = MA_CLIP; c.b_sel = MB_PCM; end
            4'd9:  begin
                c.mul_en = 1'b1; c.a_sel = MA_MIX; c.b_sel = MB_PCM; c.act = ACT_STORE;
            end
            4'd10: begin c.act = ACT_EMIT; c.jmp = JMP_WAIT_OUT; end
            default: begin c.act = ACT_NONE; c.jmp = JMP_WAIT_OUT; end
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            return -32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    function automatic logic signed [24:0] clip_unit(input logic signed [33:0] v);
        if (v > 34'sd8388608) begin
            return 25'sd8388608;
        end else if (v < -34'sd8388608) begin
            return -25'sd8388608;
        end
        return 25'(v);
    endfunction

    // truncate toward zero a product scaled by 2^23
    function automatic logic signed [15:0] trunc_q23(input logic signed [48:0] v);
        logic signed [48:0] t;
        t = v[48] ? v + 49'sd8388607 : v;
        return 16'(t >>> 23);
    endfunction

endpackage

// File: design/svfe_in_if.sv
// Input channel interface: one voice sample with filter coefficients.
interface svfe_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] voice_sum;
    logic [15:0] cutoff_coef;
    logic [15:0] resonance_coef;

    modport source (output valid, output voice_sum, output cutoff_coef,
                    output resonance_coef, input ready);
    modport sink   (input valid, input voice_sum, input cutoff_coef,
                    input resonance_coef, output ready);
endinterface

// File: design/svfe_out_if.sv
// Output channel interface: one PCM sample and DAC code.
interface svfe_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] pcm_sample;
    logic [7:0]  dac_code;

    modport source (output valid, output pcm_sample, output dac_code, input ready);
    modport sink   (input valid, input pcm_sample, input dac_code, output ready);
endinterface

// File: design/svfe_useq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module svfe_useq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  svfe_pkg::t_seq_cond  i_cond,
    output svfe_pkg::t_ctrl      o_ctrl
);

    svfe_pkg::t_step r_step;
    svfe_pkg::t_step n_step;
    svfe_pkg::t_ctrl w_ctrl;

    assign w_ctrl = svfe_pkg::ucode(r_step);
    assign o_ctrl = w_ctrl;

    always_comb begin
        case (w_ctrl.jmp)
            svfe_pkg::JMP_NEXT:     n_step = r_step + 1'b1;
            svfe_pkg::JMP_WAIT_IN:  n_step = i_cond.go ? r_step + 1'b1 : r_step;
            svfe_pkg::JMP_WAIT_OUT: n_step = i_cond.hold ? r_step : '0;
            default:                n_step = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// File: design/svf_echo_audio_chain_unit.sv
// Top level of the echo audio chain: SVF low-pass, echo ring and output scaling.
//
//  Channel    Dir  Handshake       Payload
//  i_sample   in   valid/ready     voice_sum s16, cutoff_coef u16, resonance_coef u16
//  o_result   out  valid/ready     pcm_sample s16, dac_code u8
//  i_cfg_*    in   write enable    delay_mode u3
//
//  A microcoded program of 11 steps drives one shared 32x17 multiplier, so the
//  multiplier and the step count set the rate.
//  Reset (synchronous, active low) clears filter state, ring head, fill count,
//  phase and delay mode; the ring needs no clearing pass, its fill count masks
//  entries not yet written. A stalled result holds in the output register while
//  the next sample is taken and computed; only the final step waits for it.
module svf_echo_audio_chain_unit #(
    parameter int SAMPLE_HZ         = 16000,
    parameter int DOWNSAMPLE_FACTOR = 4,
    parameter int MAX_ECHO_MS       = 1200
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_data,
    svfe_in_if.sink     i_sample,
    svfe_out_if.source  o_result
);

    // ring geometry
    localparam int ECHO_RAW = ((SAMPLE_HZ * MAX_ECHO_MS) / 1000) / DOWNSAMPLE_FACTOR;
    localparam int ECHO_LEN = (ECHO_RAW > 0) ? ECHO_RAW : 1;
    localparam int HW       = (ECHO_LEN > 1) ? $clog2(ECHO_LEN) : 1;
    localparam int FW       = $clog2(ECHO_LEN + 1);
    localparam int PW       = (DOWNSAMPLE_FACTOR > 1) ? $clog2(DOWNSAMPLE_FACTOR) : 1;

    // tap lengths for modes one to four, capped at the ring length
    localparam int TAPS_RAW1 = ((SAMPLE_HZ / DOWNSAMPLE_FACTOR) * 300) / 1000;
    localparam int TAPS_RAW2 = ((SAMPLE_HZ / DOWNSAMPLE_FACTOR) * 600) / 1000;
    localparam int TAPS_RAW3 = ((SAMPLE_HZ / DOWNSAMPLE_FACTOR) * 900) / 1000;
    localparam int TAPS_RAW4 = ((SAMPLE_HZ / DOWNSAMPLE_FACTOR) * 1200) / 1000;
    localparam logic [FW-1:0] TAPS1 = FW'((TAPS_RAW1 > ECHO_LEN) ? ECHO_LEN : TAPS_RAW1);
    localparam logic [FW-1:0] TAPS2 = FW'((TAPS_RAW2 > ECHO_LEN) ? ECHO_LEN : TAPS_RAW2);
    localparam logic [FW-1:0] TAPS3 = FW'((TAPS_RAW3 > ECHO_LEN) ? ECHO_LEN : TAPS_RAW3);
    localparam logic [FW-1:0] TAPS4 = FW'((TAPS_RAW4 > ECHO_LEN) ? ECHO_LEN : TAPS_RAW4);

    localparam logic [FW:0]   LEN_X   = (FW+1)'(ECHO_LEN);
    localparam logic [FW-1:0] LEN_F   = FW'(ECHO_LEN);
    localparam logic [HW-1:0] HEAD_LAST = HW'(ECHO_LEN - 1);
    localparam logic [PW:0]   PH_WRAP = (PW+1)'(DOWNSAMPLE_FACTOR);

    // sequencer
    svfe_pkg::t_ctrl     w_ctrl;
    svfe_pkg::t_seq_cond w_cond;

    logic w_in_acc;
    logic w_hold;

    // drop ready while reset is held so no transaction is taken then
    assign i_sample.ready = i_rst_n && (w_ctrl.act == svfe_pkg::ACT_LATCH);
    assign w_in_acc       = i_sample.valid && i_sample.ready;
    assign w_hold         = o_result.valid && !o_result.ready;
    assign w_cond.go      = i_sample.valid;
    assign w_cond.hold    = w_hold;

    svfe_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cond  (w_cond),
        .o_ctrl  (w_ctrl)
    );

    // configuration and state
    logic [2:0]         r_mode;
    logic signed [24:0] r_x;
    logic [15:0]        r_f;
    logic [15:0]        r_q;
    logic signed [31:0] r_low;
    logic signed [31:0] r_band;
    logic signed [31:0] r_high;
    logic signed [48:0] r_p;
    logic signed [24:0] r_dly;
    logic signed [24:0] r_clip;
    logic signed [24:0] r_mix;
    logic [HW-1:0]      r_head;
    logic [FW-1:0]      r_fill;
    logic [PW-1:0]      r_phase;
    logic signed [15:0] r_pcm;
    logic [7:0]         r_dac;
    logic               r_ovalid;

    // echo ring
    logic signed [15:0] r_echo [ECHO_LEN];
    logic signed [15:0] r_rd;
    logic               r_rd_ok;

    // tap address: head minus tap length, modulo ring length
    logic [FW-1:0] w_taps;
    logic [FW:0]   w_pos_sum;
    logic [FW:0]   w_pos_w;
    logic [HW-1:0] w_pos;
    logic          w_delay_on;

    assign w_delay_on = (r_mode != 3'd0);

    always_comb begin
        case (r_mode)
            3'd1:    w_taps = TAPS1;
            3'd2:    w_taps = TAPS2;
            3'd3:    w_taps = TAPS3;
            default: w_taps = TAPS4;   // four and above read at mode four
        endcase
    end

    assign w_pos_sum = (FW+1)'(r_head) + LEN_X - (FW+1)'(w_taps);
    assign w_pos_w   = (w_pos_sum >= LEN_X) ? (w_pos_sum - LEN_X) : w_pos_sum;
    assign w_pos     = w_pos_w[HW-1:0];

    // read the tap every cycle; the address only moves on a ring write or a mode write
    always_ff @(posedge i_clk) begin
        r_rd    <= r_echo[w_pos];
        r_rd_ok <= (w_pos_w < (FW+1)'(r_fill));
    end

    // shared multiplier: signed 32 by unsigned 16
    logic signed [31:0] w_a;
    logic [15:0]        w_b;
    logic signed [16:0] w_b_s;
    logic signed [48:0] w_prod;
    logic signed [15:0] w_entry;

    // unwritten entries and a disabled delay read as zero
    assign w_entry = (r_rd_ok && w_delay_on) ? r_rd : 16'sd0;

    always_comb begin
        case (w_ctrl.a_sel)
            svfe_pkg::MA_BAND:  w_a = r_band;
            svfe_pkg::MA_HIGH:  w_a = r_high;
            svfe_pkg::MA_ENTRY: w_a = 32'(w_entry);
            svfe_pkg::MA_DRY:   w_a = r_low;
            svfe_pkg::MA_CLIP:  w_a = 32'(r_clip);
            svfe_pkg::MA_MIX:   w_a = 32'(r_mix);
            default:            w_a = 32'sd0;
        endcase
    end

    always_comb begin
        case (w_ctrl.b_sel)
            svfe_pkg::MB_F:   w_b = r_f;
            svfe_pkg::MB_Q:   w_b = r_q;
            svfe_pkg::MB_TAP: w_b = svfe_pkg::TAP_GAIN;
            svfe_pkg::MB_DRY: w_b = svfe_pkg::DRY_FB_GAIN;
            svfe_pkg::MB_PCM: w_b = svfe_pkg::PCM_SCALE;
            default:          w_b = 16'd0;
        endcase
    end

    assign w_b_s  = $signed({1'b0, w_b});
    assign w_prod = 49'(w_a) * 49'(w_b_s);

    // product scaled back by 2^16, floor rounding
    logic signed [32:0] w_psh;
    assign w_psh = 33'(r_p >>> 16);

    // decimation phase and ring write
    logic [PW:0]        w_ph_inc;
    logic [PW-1:0]      w_ph_next;
    logic               w_ring_we;
    logic signed [15:0] w_ring_wd;

    assign w_ph_inc  = (PW+1)'(r_phase) + 1'b1;
    assign w_ph_next = (w_ph_inc >= PH_WRAP) ? '0 : w_ph_inc[PW-1:0];
    assign w_ring_we = (w_ctrl.act == svfe_pkg::ACT_STORE) && (w_ph_next == '0);
    assign w_ring_wd = w_delay_on ? svfe_pkg::trunc_q23(r_p) : 16'sd0;

    always_ff @(posedge i_clk) begin
        if (w_ring_we) begin
            r_echo[r_head] <= w_ring_wd;
        end
    end

    // DAC code: (s + 1.0) * 255 / 2, held to 255
    logic signed [25:0] w_off;
    logic [33:0]        w_dac_full;
    logic [8:0]         w_dac9;
    logic [7:0]         w_dac;

    assign w_off      = 26'(r_mix) + 26'sd8388608;
    assign w_dac_full = 34'({w_off[24:0], 8'h00}) - 34'(w_off[24:0]);
    assign w_dac9     = w_dac_full[32:24];
    assign w_dac      = (w_dac9 > 9'd255) ? 8'd255 : w_dac9[7:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= 3'd0;
            r_low    <= 32'sd0;
            r_band   <= 32'sd0;
            r_head   <= '0;
            r_fill   <= '0;
            r_phase  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_data;
            end
            case (w_ctrl.act)
                svfe_pkg::ACT_LOW: begin
                    r_low <= svfe_pkg::sat32(35'(r_low) + 35'(w_psh));
                end
                svfe_pkg::ACT_BAND: begin
                    r_band <= svfe_pkg::sat32(35'(r_band) + 35'(w_psh));
                end
                svfe_pkg::ACT_STORE: begin
                    r_phase <= w_ph_next;
                    if (w_ph_next == '0) begin
                        r_head <= (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
                        if (r_fill != LEN_F) begin
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            // drop the result once taken, load the next when the slot frees
            if (o_result.valid && o_result.ready) begin
                r_ovalid <= 1'b0;
            end
            if ((w_ctrl.act == svfe_pkg::ACT_EMIT) && !w_hold) begin
                r_ovalid <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_ctrl.mul_en) begin
            r_p <= w_prod;
        end
        case (w_ctrl.act)
            svfe_pkg::ACT_LATCH: begin
                if (w_in_acc) begin
                    r_x <= {i_sample.voice_sum, 9'h000};
                    r_f <= i_sample.cutoff_coef;
                    r_q <= i_sample.resonance_coef;
                end
            end
            svfe_pkg::ACT_HIGH: begin
                r_high <= svfe_pkg::sat32(35'(r_x) - 35'(r_low) - 35'(w_psh));
            end
            svfe_pkg::ACT_DLY: begin
                r_dly <= 25'(r_p);
            end
            svfe_pkg::ACT_FB: begin
                r_clip <= svfe_pkg::clip_unit(34'(r_dly >>> 2) + 34'(w_psh));
                r_mix  <= svfe_pkg::clip_unit(34'(r_low) + 34'(r_dly >>> 1));
            end
            svfe_pkg::ACT_EMIT: begin
                if (!w_hold) begin
                    r_pcm <= svfe_pkg::trunc_q23(r_p);
                    r_dac <= w_dac;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_result.valid      = r_ovalid;
    assign o_result.pcm_sample = r_pcm;
    assign o_result.dac_code   = r_dac;

endmodule

// File: design/svfe_checker.sv
// Port-level checker for the echo audio chain and its bind to the top level.
module svfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_pcm,
    input logic [7:0]  i_dac
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pcm) && $stable(i_dac)))
        else $error("stalled result changed");

    // one sample at a time: no accept right after an accept
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("input taken while a sample is in work");

    a_pcm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (($signed(i_pcm) <= 16'sd30000) && ($signed(i_pcm) >= -16'sd30000)))
        else $error("pcm sample out of range");

    a_full_scale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && ($signed(i_pcm) == 16'sd30000)) |-> (i_dac == 8'd255))
        else $error("full scale pcm without full scale dac code");

endmodule

bind svf_echo_audio_chain_unit svfe_checker u_svfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_sample.valid),
    .i_in_ready  (i_sample.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_pcm       (o_result.pcm_sample),
    .i_dac       (o_result.dac_code)
);

// File: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for the echo audio chain: drives voice samples, predicts PCM and DAC output.
module testbench;

    // Block geometry, matched to the default parameters of the unit.
    localparam int SAMPLE_HZ   = 16000;
    localparam int DECIMATE    = 4;
    localparam int MAX_ECHO_MS = 1200;
    localparam int ECHO_DEPTH  = SAMPLE_HZ * MAX_ECHO_MS / 1000 / DECIMATE;

    // Delay mode values; anything above the longest tap behaves as the longest tap.
    localparam logic [2:0] DELAY_OFF     = 3'd0;
    localparam logic [2:0] DELAY_LONGEST = 3'd4;
    localparam int         MS_PER_MODE   = 300;

    // Q8.23 arithmetic constants.
    localparam longint UNIT_Q23    = 64'sd8388608;
    localparam longint TAP_WEIGHT  = 64'sd280;
    localparam longint FB_DRY_GAIN = 64'sd45875;
    localparam longint PCM_FULL    = 64'sd30000;
    localparam longint DAC_TOP     = 64'sd255;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 12;
    // One sample runs 11 microcode steps; leave a little margin on top.
    localparam int SETTLE_CYCLES = 24;
    // Slowest legal run covers ~1300 samples; the watchdog allows ~5x its length.
    localparam int WATCHDOG_NS   = 2_600_000;

    typedef struct packed {
        logic [15:0] voice_sum;
        logic [15:0] cutoff_coef;
        logic [15:0] resonance_coef;
    } t_voice_in;

    typedef struct packed {
        logic [15:0] pcm_sample;
        logic [7:0]  dac_code;
    } t_audio_out;

    logic       i_clk      = 1'b0;
    logic       i_rst_n    = 1'b0;
    logic       i_cfg_we   = 1'b0;
    logic [2:0] i_cfg_data = DELAY_OFF;

    svfe_in_if  sample_if ();
    svfe_out_if result_if ();

    // Source side of the sample channel and sink side of the result channel.
    logic      feed_valid = 1'b0;
    t_voice_in feed_item  = '0;
    logic      take_ready = 1'b0;
    int        feed_gap   = 0;
    int        take_gap   = 0;
    bit        idling_on  = 1'b1;

    assign sample_if.valid          = feed_valid;
    assign sample_if.voice_sum      = feed_item.voice_sum;
    assign sample_if.cutoff_coef    = feed_item.cutoff_coef;
    assign sample_if.resonance_coef = feed_item.resonance_coef;
    assign result_if.ready          = take_ready;

    svf_echo_audio_chain_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_sample   (sample_if),
        .o_result   (result_if)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // Samples waiting to be offered, and predicted outputs waiting for the block.
    t_voice_in  voice_backlog [$];
    t_audio_out awaited_audio [$];
    int         mismatch_count = 0;

    // Shadow of the block state, advanced once per accepted sample.
    logic [2:0]         delay_mode_q = DELAY_OFF;
    logic signed [31:0] lowpass_q    = '0;
    logic signed [31:0] bandpass_q   = '0;
    logic signed [15:0] echo_ring [ECHO_DEPTH];
    logic [12:0]        echo_head_q  = '0;
    logic [1:0]         phase_q      = '0;

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return 32'(v);
    endfunction

    function automatic longint limit_pm_one(input longint v);
        if (v > UNIT_Q23) begin
            return UNIT_Q23;
        end else if (v < -UNIT_Q23) begin
            return -UNIT_Q23;
        end
        return v;
    endfunction

    // Advance the shadow filter and echo ring by one sample and return what the
    // block must emit for it.
    function automatic t_audio_out chain_response(input t_voice_in v);
        longint     x, f, q, high, dry, delayed, mix, fb, s, pcm, dac, taps;
        int         eff_mode;
        int         tap_pos;
        t_audio_out r;
        x = longint'($signed(v.voice_sum)) * 512;
        f = longint'(v.cutoff_coef);
        q = longint'(v.resonance_coef);
        eff_mode = (delay_mode_q > DELAY_LONGEST) ? int'(DELAY_LONGEST) : int'(delay_mode_q);

        // State-variable low-pass; the low output is the dry signal.
        lowpass_q  = clamp32(longint'(lowpass_q) + ((f * longint'(bandpass_q)) >>> 16));
        high       = clamp32(x - longint'(lowpass_q) - ((q * longint'(bandpass_q)) >>> 16));
        bandpass_q = clamp32(longint'(bandpass_q) + ((f * high) >>> 16));
        dry        = longint'(lowpass_q);

        if (phase_q == 2'(DECIMATE - 1)) begin
            phase_q = '0;
        end else begin
            phase_q = phase_q + 2'd1;
        end

        // Read the tap before this sample's write; a full-length tap lands on the head.
        delayed = 0;
        if (eff_mode != 0) begin
            taps = longint'(SAMPLE_HZ / DECIMATE) * eff_mode * MS_PER_MODE / 1000;
            if (taps > ECHO_DEPTH) begin
                taps = ECHO_DEPTH;
            end
            tap_pos = int'((longint'(echo_head_q) + ECHO_DEPTH - taps) % ECHO_DEPTH);
            delayed = longint'(echo_ring[tap_pos]) * TAP_WEIGHT;
        end
        mix = dry + (delayed >>> 1);

        // Feed the ring once per decimation period; store silence while delay is off.
        if (phase_q == 2'd0) begin
            if (eff_mode != 0) begin
                fb = limit_pm_one((delayed >>> 2) + ((dry * FB_DRY_GAIN) >>> 16));
                echo_ring[echo_head_q] = 16'((fb * PCM_FULL) / UNIT_Q23);
            end else begin
                echo_ring[echo_head_q] = '0;
            end
            if (int'(echo_head_q) == ECHO_DEPTH - 1) begin
                echo_head_q = '0;
            end else begin
                echo_head_q = echo_head_q + 13'd1;
            end
        end

        s   = limit_pm_one(mix);
        pcm = (s * PCM_FULL) / UNIT_Q23;
        dac = ((s + UNIT_Q23) * DAC_TOP) / (2 * UNIT_Q23);
        if (dac < 0) begin
            dac = 0;
        end else if (dac > DAC_TOP) begin
            dac = DAC_TOP;
        end
        r.pcm_sample = 16'(pcm);
        r.dac_code   = 8'(dac);
        return r;
    endfunction

    // Count and report every failure.
    function automatic void note_failure(input string msg);
        mismatch_count++;
        $error("%s", msg);
    endfunction

    // Mostly audio-like samples with a moderately damped filter, so the low-pass
    // carries real signal into the echo ring; the rest are raw 16-bit values or field extremes.
    function automatic t_voice_in random_voice();
        t_voice_in v;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            v.voice_sum      = 16'($urandom_range(0, 32767) - 16384);
            v.cutoff_coef    = 16'($urandom_range(300, 24000));
            v.resonance_coef = 16'($urandom_range(12000, 65535));
        end else if (pick < 95) begin
            v.voice_sum      = 16'($urandom());
            v.cutoff_coef    = 16'($urandom());
            v.resonance_coef = 16'($urandom());
        end else begin
            v.voice_sum      = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            v.cutoff_coef    = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            v.resonance_coef = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        end
        return v;
    endfunction

    // Offer queued samples; on every transaction predict the output it causes.
    always @(posedge i_clk) begin : feed_voice
        logic      next_valid;
        t_voice_in next_item;
        next_valid = feed_valid;
        next_item  = feed_item;
        if (!i_rst_n) begin
            next_valid = 1'b0;
            feed_gap   = 0;
        end else begin
            if (feed_valid && sample_if.ready) begin
                awaited_audio.push_back(chain_response(feed_item));
                next_valid = 1'b0;
            end
            // Hold valid through a stall; a free slot may start an idle burst.
            if (!next_valid) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else if (idling_on && $urandom_range(0, 15) == 0) begin
                    feed_gap = $urandom_range(0, 13);
                end else if (voice_backlog.size() != 0) begin
                    next_item  = voice_backlog.pop_front();
                    next_valid = 1'b1;
                end
            end
        end
        feed_valid <= next_valid;
        feed_item  <= next_item;
    end

    // Accept results with random backpressure and check them in order.
    always @(posedge i_clk) begin : take_audio
        t_audio_out want;
        if (!i_rst_n) begin
            take_ready <= 1'b0;
            take_gap = 0;
        end else begin
            if (result_if.valid && take_ready) begin
                if (awaited_audio.size() == 0) begin
                    note_failure($sformatf("unexpected result: pcm_sample %0d dac_code %0d",
                                           $signed(result_if.pcm_sample), result_if.dac_code));
                end else begin
                    want = awaited_audio.pop_front();
                    if (result_if.pcm_sample !== want.pcm_sample) begin
                        note_failure($sformatf("pcm_sample: expected %0d, actual %0d",
                                               $signed(want.pcm_sample),
                                               $signed(result_if.pcm_sample)));
                    end
                    if (result_if.dac_code !== want.dac_code) begin
                        note_failure($sformatf("dac_code: expected %0d, actual %0d",
                                               want.dac_code, result_if.dac_code));
                    end
                end
            end
            if (take_gap > 0) begin
                take_gap--;
                take_ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 15) == 0) begin
                take_gap = $urandom_range(0, 13);
                take_ready <= 1'b0;
            end else begin
                take_ready <= 1'b1;
            end
        end
    end

    task automatic push_voice(input logic [15:0] vs, input logic [15:0] f,
                              input logic [15:0] q);
        voice_backlog.push_back('{voice_sum: vs, cutoff_coef: f, resonance_coef: q});
    endtask

    // Block until every queued sample has gone in and every output has come back.
    task automatic wait_until_idle();
        while (voice_backlog.size() != 0 || feed_valid || awaited_audio.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic change_mode(input logic [2:0] mode);
        wait_until_idle();
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= mode;
        @(posedge i_clk);
        i_cfg_we     <= 1'b0;
        delay_mode_q = mode;
    endtask

    task automatic run_random(input logic [2:0] mode, input int count, input bit idle);
        change_mode(mode);
        idling_on = idle;
        repeat (count) voice_backlog.push_back(random_voice());
    endtask

    initial begin : stimulus
        for (int i = 0; i < ECHO_DEPTH; i++) begin
            echo_ring[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples with the delay off (reset value): field extremes,
        // a push toward accumulator saturation with no damping, alternating bits.
        push_voice(16'h0000, 16'h0000, 16'h0000);
        push_voice(16'h7FFF, 16'hFFFF, 16'h0000);
        push_voice(16'h7FFF, 16'hFFFF, 16'h0000);
        push_voice(16'h8000, 16'hFFFF, 16'h0000);
        push_voice(16'h8000, 16'hFFFF, 16'h0000);
        push_voice(16'h7FFF, 16'hFFFF, 16'h0000);
        push_voice(16'h8000, 16'h0000, 16'hFFFF);
        push_voice(16'h7FFF, 16'h0000, 16'h0000);
        push_voice(16'h0001, 16'h0001, 16'h0001);
        push_voice(16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_voice(16'h0000, 16'h8000, 16'h8000);
        push_voice(16'h5555, 16'hAAAA, 16'h5555);
        push_voice(16'hAAAA, 16'h5555, 16'hAAAA);
        push_voice(16'h0000, 16'hFFFF, 16'hFFFF);

        // Delay mode above the longest tap must act as the longest tap.
        change_mode(3'd7);
        push_voice(16'h7FFF, 16'd20000, 16'd40000);
        push_voice(16'h8000, 16'd20000, 16'd40000);
        push_voice(16'h0000, 16'h0000, 16'h0000);

        // Sweep every delay mode, including the ones above the longest tap, and
        // keep the ring write path and decimation phase busy throughout.
        run_random(3'd3, 150, 1'b1);
        run_random(DELAY_OFF, 100, 1'b1);
        run_random(3'd1, 200, 1'b1);
        run_random(3'd2, 150, 1'b1);
        run_random(3'd5, 80, 1'b1);
        run_random(3'd3, 150, 1'b1);
        run_random(DELAY_LONGEST, 200, 1'b1);
        run_random(3'd7, 80, 1'b1);
        // Last stretch runs at full rate with no idling on either side.
        run_random(3'd6, 60, 1'b0);
        run_random(3'd1, 60, 1'b0);
        run_random(DELAY_OFF, 50, 1'b0);

        wait_until_idle();
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #(WATCHDOG_NS);
        $display("Regression FAIL");
        $finish;
    end

endmodule
